/* rtl/core/att_pkg.sv */
// ----------------------------------------------------------------------------
// att_pkg
// shared types, codes and parameter defaults for the alarm timetable
// ----------------------------------------------------------------------------
`default_nettype none

package att_pkg;

  localparam int SLOTS_DEF     = 32;
  localparam int ID_BITS_DEF   = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [1:0] KIND_PROGRAM = 2'd0;
  localparam logic [1:0] KIND_CANCEL  = 2'd1;
  localparam logic [1:0] KIND_QUERY   = 2'd2;
  localparam logic [1:0] KIND_REFRESH = 2'd3;

  localparam logic [1:0] STATUS_NOT_FOUND = 2'd0;
  localparam logic [1:0] STATUS_FOUND     = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] alarm_id;
    logic [31:0] time_value;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] old_time;
    logic        fired;
    logic [15:0] fired_id;
    logic [31:0] lateness;
    logic [5:0]  fired_count;
    logic        last;
  } rsp_item_t;

  typedef struct packed {
    logic match_hit;
    logic free_hit;
    logic best_hit;
  } scan_flags_t;

endpackage

`default_nettype wire

/* rtl/core/alarm_timetable_top.sv */
// ----------------------------------------------------------------------------
// alarm_timetable_top
// table of pending alarms with program, cancel, query and refresh items
// ----------------------------------------------------------------------------
// Program, cancel and query each make one pass over the table, reading one slot
// per cycle from the id/time ram through a single compare unit. A refresh makes
// one pass per fired alarm plus one final pass, and each decision also waits for
// the previous result to leave the output register.
// No item is taken while a pass is running.
`default_nettype none

module alarm_timetable_top #(
  parameter int SLOTS     = att_pkg::SLOTS_DEF,
  parameter int ID_BITS   = att_pkg::ID_BITS_DEF,
  parameter int TIME_BITS = att_pkg::TIME_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire att_pkg::req_item_t  req,
  output logic                     rsp_valid,
  input  wire logic                rsp_stall,
  output att_pkg::rsp_item_t       rsp
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_DECIDE = 3'b100
  } state_t;

  state_t                  state;
  logic [1:0]              kind;
  logic [ID_BITS-1:0]      key_id;
  logic [TIME_BITS-1:0]    bound;
  logic [AW-1:0]           scan_idx;
  logic                    issue_done;
  logic                    rd_vld;
  logic [AW-1:0]           rd_idx;
  logic [CW-1:0]           fire_cnt;
  logic [SLOTS-1:0]        slot_valid;

  logic                    accept;
  logic                    issue;
  logic                    out_free;
  logic                    decide;
  logic                    pass_end;
  logic                    restart;
  logic                    scan_clear;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [ID_BITS+TIME_BITS-1:0] ram_rdata;

  att_pkg::scan_flags_t    flags;
  logic [AW-1:0]           match_idx;
  logic [TIME_BITS-1:0]    match_time;
  logic [AW-1:0]           free_idx;
  logic [AW-1:0]           best_idx;
  logic [ID_BITS-1:0]      best_id;
  logic [TIME_BITS-1:0]    best_time;
  logic [TIME_BITS-1:0]    late;

  logic                    set_vld;
  logic                    clr_vld;
  logic [AW-1:0]           vld_idx;
  logic                    last_rsp;
  att_pkg::rsp_item_t      rsp_next;

  assign req_stall  = (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign issue      = (state == S_SCAN) && !issue_done;
  assign out_free   = !rsp_valid || !rsp_stall;
  assign decide     = (state == S_DECIDE) && out_free;
  assign pass_end   = rd_vld && (rd_idx == AW'(SLOTS - 1));
  assign restart    = decide && !last_rsp;
  assign scan_clear = accept || restart;
  assign late       = bound - best_time;

  att_ram #(
    .WIDTH (ID_BITS + TIME_BITS),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({key_id, bound}),
    .re    (issue),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  att_scan #(
    .SLOTS     (SLOTS),
    .ID_BITS   (ID_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .clear      (scan_clear),
    .en         (rd_vld),
    .limited    (kind == att_pkg::KIND_REFRESH),
    .idx        (rd_idx),
    .slot_vld   (slot_valid[rd_idx]),
    .rd_id      (ram_rdata[ID_BITS+TIME_BITS-1:TIME_BITS]),
    .rd_time    (ram_rdata[TIME_BITS-1:0]),
    .key_id     (key_id),
    .bound      (bound),
    .flags      (flags),
    .match_idx  (match_idx),
    .match_time (match_time),
    .free_idx   (free_idx),
    .best_idx   (best_idx),
    .best_id    (best_id),
    .best_time  (best_time)
  );

  always_comb begin
    rsp_next  = '0;
    set_vld   = 1'b0;
    clr_vld   = 1'b0;
    vld_idx   = match_idx;
    ram_we    = 1'b0;
    ram_waddr = match_idx;
    last_rsp  = 1'b1;
    rsp_next.last = 1'b1;
    unique case (kind)
      att_pkg::KIND_PROGRAM: begin
        if (flags.match_hit) begin
          ram_we            = decide;
          rsp_next.status   = att_pkg::STATUS_FOUND;
          rsp_next.old_time = 32'(match_time);
        end else if (flags.free_hit) begin
          ram_we          = decide;
          ram_waddr       = free_idx;
          set_vld         = decide;
          vld_idx         = free_idx;
          rsp_next.status = att_pkg::STATUS_NOT_FOUND;
        end else begin
          rsp_next.status = att_pkg::STATUS_FULL;
        end
      end
      att_pkg::KIND_CANCEL: begin
        if (flags.match_hit) begin
          clr_vld           = decide;
          rsp_next.status   = att_pkg::STATUS_FOUND;
          rsp_next.old_time = 32'(match_time);
        end
      end
      att_pkg::KIND_QUERY: begin
        if (flags.best_hit) begin
          rsp_next.status   = att_pkg::STATUS_FOUND;
          rsp_next.old_time = 32'(best_time);
        end
      end
      att_pkg::KIND_REFRESH: begin
        if (flags.best_hit) begin
          clr_vld           = decide;
          vld_idx           = best_idx;
          last_rsp          = 1'b0;
          rsp_next.status   = att_pkg::STATUS_FOUND;
          rsp_next.fired    = 1'b1;
          rsp_next.fired_id = 16'(best_id);
          rsp_next.lateness = 32'(late);
          rsp_next.last     = 1'b0;
        end else begin
          rsp_next.fired_count = 6'(fire_cnt);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind       <= att_pkg::KIND_PROGRAM;
      issue_done <= 1'b0;
      rd_vld     <= 1'b0;
      slot_valid <= '0;
      rsp_valid  <= 1'b0;
      fire_cnt   <= '0;
    end else begin
      rd_vld <= issue;
      rd_idx <= scan_idx;
      if (issue) begin
        if (scan_idx == AW'(SLOTS - 1)) begin
          issue_done <= 1'b1;
        end else begin
          scan_idx <= scan_idx + AW'(1);
        end
      end
      if (scan_clear) begin
        scan_idx   <= '0;
        issue_done <= 1'b0;
      end
      if (set_vld) begin
        slot_valid[vld_idx] <= 1'b1;
      end
      if (clr_vld) begin
        slot_valid[vld_idx] <= 1'b0;
      end
      if (decide) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_SCAN;
            kind     <= req.kind;
            key_id   <= ID_BITS'(req.alarm_id);
            bound    <= TIME_BITS'(req.time_value);
            fire_cnt <= '0;
          end
        end
        S_SCAN: begin
          if (pass_end) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (decide) begin
            if (last_rsp) begin
              state <= S_IDLE;
            end else begin
              state    <= S_SCAN;
              fire_cnt <= fire_cnt + CW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/att_ram.sv */
// ----------------------------------------------------------------------------
// att_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module att_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/att_scan.sv */
// ----------------------------------------------------------------------------
// att_scan
// compare unit and accumulators, fed one slot per cycle during a table pass
// ----------------------------------------------------------------------------
`default_nettype none

module att_scan #(
  parameter int SLOTS     = att_pkg::SLOTS_DEF,
  parameter int ID_BITS   = att_pkg::ID_BITS_DEF,
  parameter int TIME_BITS = att_pkg::TIME_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear,
  input  wire logic                       en,
  input  wire logic                       limited,
  input  wire logic [$clog2(SLOTS)-1:0]   idx,
  input  wire logic                       slot_vld,
  input  wire logic [ID_BITS-1:0]         rd_id,
  input  wire logic [TIME_BITS-1:0]       rd_time,
  input  wire logic [ID_BITS-1:0]         key_id,
  input  wire logic [TIME_BITS-1:0]       bound,
  output att_pkg::scan_flags_t            flags,
  output logic      [$clog2(SLOTS)-1:0]   match_idx,
  output logic      [TIME_BITS-1:0]       match_time,
  output logic      [$clog2(SLOTS)-1:0]   free_idx,
  output logic      [$clog2(SLOTS)-1:0]   best_idx,
  output logic      [ID_BITS-1:0]         best_id,
  output logic      [TIME_BITS-1:0]       best_time
);

  logic eligible;
  logic take_best;
  logic take_match;
  logic take_free;

  assign eligible   = slot_vld && (!limited || (rd_time <= bound));
  assign take_best  = en && eligible && (!flags.best_hit || (rd_time < best_time));
  assign take_match = en && slot_vld && (rd_id == key_id) && !flags.match_hit;
  assign take_free  = en && !slot_vld && !flags.free_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (clear) begin
      flags <= '0;
    end else begin
      if (take_best) begin
        flags.best_hit <= 1'b1;
        best_idx       <= idx;
        best_id        <= rd_id;
        best_time      <= rd_time;
      end
      if (take_match) begin
        flags.match_hit <= 1'b1;
        match_idx       <= idx;
        match_time      <= rd_time;
      end
      if (take_free) begin
        flags.free_hit <= 1'b1;
        free_idx       <= idx;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/att_chk.sv */
// ----------------------------------------------------------------------------
// att_chk
// port level checks for the alarm timetable, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module att_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_stall,
  input wire logic               rsp_valid,
  input wire logic               rsp_stall,
  input wire att_pkg::rsp_item_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item taken while a pass is running");

  a_fired_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.fired |-> !rsp.last && rsp.status == att_pkg::STATUS_FOUND
      && rsp.old_time == 32'd0 && rsp.fired_count == 6'd0)
    else $error("bad fired result item");

  a_only_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.fired)
    else $error("non final result item is not a fired alarm");

  a_full_shape: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == att_pkg::STATUS_FULL |->
      rsp.last && !rsp.fired && rsp.old_time == 32'd0)
    else $error("bad table full result item");

endmodule

bind alarm_timetable_top att_chk u_att_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
